// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== src/nalsp_pkg.sv =====
package nalsp_pkg;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_NAL,
      PH_STOP
   } phase_type;

   localparam logic [4:0] TYPE_SLICE = 5'h01;
   localparam logic [4:0] TYPE_IDR   = 5'h05;
   localparam logic [4:0] TYPE_SEI   = 5'h06;
   localparam logic [4:0] TYPE_SPS   = 5'h07;
   localparam logic [4:0] TYPE_PPS   = 5'h08;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_SPS   = 2'd1;
   localparam logic [1:0] KIND_PPS   = 2'd2;
   localparam logic [1:0] KIND_SEI   = 2'd3;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;

   localparam int QUEUE_DEPTH = 4;

   // one input transaction worth of results: held zeros, the byte, an end marker
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] nzero;
      logic       has_data;
      logic       has_end;
      logic       is_slice;
      logic       first;
      logic [4:0] nal_type;
   } desc_type;

   localparam int DESC_BITS = $bits(desc_type);

   function automatic logic [1:0] kind_of(input logic [4:0] t);
      logic [1:0] k;
      begin
         priority if (t == TYPE_SPS) k = KIND_SPS;
         else if (t == TYPE_PPS) k = KIND_PPS;
         else if (t == TYPE_SEI) k = KIND_SEI;
         else k = KIND_OTHER;
         return k;
      end
   endfunction

endpackage

// ===== src/nalsp_queue.sv =====
module nalsp_queue
   import nalsp_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
`include "assert_macros.svh"

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]    mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff < (PTR_BITS+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

   `ASSERT_CLK(a_count_bound, count_ff <= (PTR_BITS+1)'(QUEUE_DEPTH), "queue count out of range")
   `ASSERT_CLK(a_count_track, push && !pop |=> count_ff == $past(count_ff) + 1'b1, "push lost")
   `ASSERT_CLK(a_ptr_gap, count_ff == '0 |-> wr_ff == rd_ff, "pointers apart while empty")

endmodule

// ===== src/nalsp_front.sv =====
module nalsp_front
   import nalsp_pkg::*;
#(
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   desc_valid,
   input  logic                   desc_ready,
   output desc_type               desc,
   output logic [LENGTH_BITS-1:0] desc_count
);

   phase_type              phase_ff, phase_in;
   logic [1:0]             zero_run_ff, zero_run_in;
   logic                   awaiting_ff, awaiting_in;
   logic [4:0]             type_ff, type_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   desc_type               desc_n;
   logic                   open_nal;
   logic [2:0]             npay;
   logic                   accept;

   function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [2:0] d);
      logic [LENGTH_BITS:0] s;
      begin
         s = {1'b0, a} + {{(LENGTH_BITS-2){1'b0}}, d};
         return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
      end
   endfunction

   assign req_ready  = desc_ready;
   assign accept     = req_valid && req_ready;
   assign desc       = desc_n;
   assign desc_count = count_ff;
   assign desc_valid = req_valid && (desc_n.nzero != 2'd0 || desc_n.has_data ||
                                     desc_n.has_end || desc_n.is_slice);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SEARCH;
         zero_run_ff <= '0;
         awaiting_ff <= 1'b0;
         type_ff     <= '0;
         count_ff    <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         zero_run_ff <= zero_run_in;
         awaiting_ff <= awaiting_in;
         type_ff     <= type_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      zero_run_in = zero_run_ff;
      awaiting_in = awaiting_ff;
      type_in     = type_ff;
      open_nal    = 1'b0;
      desc_n      = '0;
      desc_n.data = req_data_byte;

      unique case (phase_ff)
         PH_SEARCH: begin
            priority if (req_data_byte == BYTE_ZERO) begin
               if (zero_run_ff < 2'd2) zero_run_in = zero_run_ff + 1'b1;
            end else if (req_data_byte == BYTE_ONE && zero_run_ff == 2'd2) begin
               open_nal = 1'b1;
            end else begin
               zero_run_in = '0;
            end
         end
         PH_NAL: begin
            priority if (req_data_byte == BYTE_ZERO && zero_run_ff < 2'd2) begin
               zero_run_in = zero_run_ff + 1'b1;
            end else if (zero_run_ff == 2'd2 && req_data_byte <= BYTE_ONE) begin
               desc_n.has_end = 1'b1;
               priority if (awaiting_ff) begin
                  phase_in    = PH_STOP;
                  zero_run_in = '0;
               end else if (req_data_byte == BYTE_ONE) begin
                  open_nal = 1'b1;
               end else begin
                  phase_in    = PH_SEARCH;
                  zero_run_in = 2'd2;
               end
            end else if (awaiting_ff && zero_run_ff == 2'd0 &&
                         (req_data_byte[4:0] == TYPE_SLICE ||
                          req_data_byte[4:0] == TYPE_IDR)) begin
               desc_n.is_slice = 1'b1;
               type_in         = req_data_byte[4:0];
               awaiting_in     = 1'b0;
               phase_in        = PH_STOP;
               zero_run_in     = '0;
            end else begin
               desc_n.nzero    = zero_run_ff;
               desc_n.has_data = 1'b1;
               desc_n.first    = awaiting_ff;
               if (awaiting_ff && zero_run_ff == 2'd0) type_in = req_data_byte[4:0];
               awaiting_in     = 1'b0;
               zero_run_in     = '0;
            end
         end
         default: begin
         end
      endcase

      if (open_nal) begin
         phase_in    = PH_NAL;
         zero_run_in = '0;
         awaiting_in = 1'b1;
      end

      if (req_last_byte) begin
         if (phase_in == PH_NAL) begin
            if (zero_run_in != 2'd0) begin
               desc_n.nzero = zero_run_in;
               desc_n.first = awaiting_in;
               awaiting_in  = 1'b0;
            end
            if (!awaiting_in) desc_n.has_end = 1'b1;
         end
         phase_in    = PH_SEARCH;
         zero_run_in = '0;
         awaiting_in = 1'b0;
      end

      desc_n.nal_type = type_in;
      if (open_nal) type_in = '0;

      npay     = {1'b0, desc_n.nzero} + {2'b00, desc_n.has_data};
      count_in = open_nal ? '0 : sat_add(count_ff, npay);
   end

endmodule

// ===== src/nalsp_back.sv =====
module nalsp_back
   import nalsp_pkg::*;
#(
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   desc_valid,
   output logic                   desc_ready,
   input  desc_type               desc,
   input  logic [LENGTH_BITS-1:0] desc_count,
   output logic [7:0]             rsp_nal_byte,
   output logic                   rsp_byte_valid,
   output logic [4:0]             rsp_nal_type,
   output logic [1:0]             rsp_nal_kind,
   output logic                   rsp_first_of_nal,
   output logic                   rsp_end_of_nal,
   output logic [15:0]            rsp_nal_length,
   output logic                   rsp_slice_found,
   output logic                   rsp_last_of_run,
   output logic                   rsp_valid,
   input  logic                   rsp_ready
);
`include "assert_macros.svh"

   logic [1:0]             idx_ff, idx_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [LENGTH_BITS-1:0] base, incr;
   logic [2:0]             total, npay;
   logic                   is_pay, is_last, accept;

   function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [2:0] d);
      logic [LENGTH_BITS:0] s;
      begin
         s = {1'b0, a} + {{(LENGTH_BITS-2){1'b0}}, d};
         return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
      end
   endfunction

   always_comb begin
      npay    = desc.is_slice ? 3'd0 : {1'b0, desc.nzero} + {2'b00, desc.has_data};
      total   = desc.is_slice ? 3'd1 : npay + {2'b00, desc.has_end};
      is_pay  = {1'b0, idx_ff} < npay;
      is_last = {1'b0, idx_ff} == total - 3'd1;
      base    = (idx_ff == 2'd0) ? desc_count : count_ff;
      incr    = sat_add(base, 3'd1);

      rsp_valid        = desc_valid;
      accept           = rsp_valid && rsp_ready;
      desc_ready       = rsp_ready && is_last;
      rsp_byte_valid   = is_pay;
      rsp_nal_byte     = (is_pay && idx_ff >= desc.nzero) ? desc.data : BYTE_ZERO;
      rsp_nal_type     = desc.nal_type;
      rsp_nal_kind     = kind_of(desc.nal_type);
      rsp_first_of_nal = is_pay && idx_ff == 2'd0 && desc.first;
      rsp_end_of_nal   = !desc.is_slice && !is_pay;
      rsp_slice_found  = desc.is_slice;
      rsp_last_of_run  = is_last;
      priority if (desc.is_slice) rsp_nal_length = '0;
      else if (is_pay) rsp_nal_length = 16'(incr);
      else rsp_nal_length = 16'(base);

      idx_in   = is_last ? 2'd0 : idx_ff + 1'b1;
      count_in = is_pay ? incr : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (accept) begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         count_ff <= count_in;
      end
   end

   `ASSERT_CLK(a_idx_range, desc_valid |-> {1'b0, idx_ff} < total, "result index past run")
   `ASSERT_CLK(a_slice_alone, desc_valid && desc.is_slice |-> idx_ff == 2'd0 && is_last, "slice not single")
   `ASSERT_CLK(a_stall_hold, desc_valid && !rsp_ready |=> $stable(idx_ff), "index moved on stall")
   `ASSERT_NEVER(a_idle_index, !desc_valid && idx_ff != 2'd0, "index left mid run")

endmodule

// ===== src/h264_annexb_nal_splitter_core.sv =====
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_data_byte, req_last_byte
// rsp       out        rsp_valid/rsp_ready    nal_byte .. last_of_run, one result each
//
// one input byte is accepted per cycle while the result queue has room
// each byte yields zero to four results, delivered one per cycle by the back end while rsp_ready is high
// the sustained rate is set by the single result port
// synchronous active-high reset returns to start code search with an empty queue
// either side may stall; the four-entry queue decouples them
module h264_annexb_nal_splitter_core
   import nalsp_pkg::*;
#(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_valid,
   output logic        req_ready,
   output logic [7:0]  rsp_nal_byte,
   output logic        rsp_byte_valid,
   output logic [4:0]  rsp_nal_type,
   output logic [1:0]  rsp_nal_kind,
   output logic        rsp_first_of_nal,
   output logic        rsp_end_of_nal,
   output logic [15:0] rsp_nal_length,
   output logic        rsp_slice_found,
   output logic        rsp_last_of_run,
   output logic        rsp_valid,
   input  logic        rsp_ready
);

   localparam int QW = DESC_BITS + LENGTH_BITS;

   desc_type               f_desc, b_desc;
   logic [LENGTH_BITS-1:0] f_count, b_count;
   logic                   f_valid, f_ready, b_valid, b_ready;
   logic [QW-1:0]          q_out;

   nalsp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .desc_valid    (f_valid),
      .desc_ready    (f_ready),
      .desc          (f_desc),
      .desc_count    (f_count)
   );

   nalsp_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_desc, f_count}),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out)
   );

   assign b_desc  = desc_type'(q_out[QW-1:LENGTH_BITS]);
   assign b_count = q_out[LENGTH_BITS-1:0];

   nalsp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .desc_valid       (b_valid),
      .desc_ready       (b_ready),
      .desc             (b_desc),
      .desc_count       (b_count),
      .rsp_nal_byte     (rsp_nal_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_nal_type     (rsp_nal_type),
      .rsp_nal_kind     (rsp_nal_kind),
      .rsp_first_of_nal (rsp_first_of_nal),
      .rsp_end_of_nal   (rsp_end_of_nal),
      .rsp_nal_length   (rsp_nal_length),
      .rsp_slice_found  (rsp_slice_found),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready)
   );

endmodule
